### rtl/hme_pkg.sv
// Shared types, constants and MD5 round tables for the HMAC-MD5 engine.
// No dependencies; every other rtl file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package hme_pkg;

  // Depth of the item queue between the front and the engine
  localparam int QDEPTH = 4;

  // Item kinds, same encoding as the mode field
  typedef enum logic [1:0] {
    OP_KEY    = 2'd0,
    OP_KEYEND = 2'd1,
    OP_MSG    = 2'd2,
    OP_FIN    = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } item_t;

  // Chain words are packed with word 0 in the low bits
  typedef struct packed {
    logic         start;
    logic [127:0] chain;
  } md5_req_t;

  typedef struct packed {
    logic         busy;
    logic         done;
    logic [3:0]   widx;
    logic [127:0] chain;
  } md5_stat_t;

  localparam logic [127:0] MD5_INIT = {32'h10325476, 32'h98badcfe,
                                       32'hefcdab89, 32'h67452301};

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756; 6'd2:  k = 32'h242070db;
      6'd3:  k = 32'hc1bdceee; 6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501; 6'd8:  k = 32'h698098d8;
      6'd9:  k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  // Left-rotate amount: row is the round group, column the low two bits
  function automatic logic [4:0] md5_rot(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word index used by round i
  function automatic logic [3:0] md5_widx(input logic [5:0] i);
    logic [3:0] g;
    unique case (i[5:4])
      2'd0:    g = i[3:0];
      2'd1:    g = 4'(5 * i[3:0] + 1);
      2'd2:    g = 4'(3 * i[3:0] + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

### rtl/hme_front.sv
// Input front of the HMAC-MD5 engine: accepts beats, classifies the mode
// and holds them in a short queue. Depends on hme_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hme_front import hme_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [7:0] data_byte,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  localparam int AW = $clog2(QDEPTH);

  item_t         mem [QDEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          push;
  logic          pop;

  assign in_stall = (count == (AW+1)'(QDEPTH));
  assign push     = in_valid & ~in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_pop & q_valid;
  assign q_item   = mem[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

  // Classify and store the beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{op: op_t'(mode), data: data_byte};
    end
  end

endmodule
`default_nettype wire

### rtl/hme_md5.sv
// MD5 compression unit: one round per cycle, 64 rounds per block.
// Fetches one message word per round through widx. Depends on hme_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hme_md5 import hme_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  md5_req_t    req,
  input  logic [31:0] word,
  output md5_stat_t   stat
);

  logic [31:0]  a, b, c, d;
  logic [127:0] h;
  logic [5:0]   rnd;
  logic         busy;
  logic         done;
  logic [31:0]  f;
  logic [31:0]  t;
  logic [63:0]  tt;

  // Round function and rotate
  always_comb begin
    unique case (rnd[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (d & b) | (~d & c);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    t  = a + f + md5_k(rnd) + word;
    tt = {t, t} << md5_rot(rnd);
  end

  assign stat.busy  = busy;
  assign stat.done  = done;
  assign stat.widx  = md5_widx(rnd);
  assign stat.chain = {h[127:96] + d, h[95:64] + c, h[63:32] + b, h[31:0] + a};

  // Round counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 1'b1;
        if (rnd == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Working variables
  always_ff @(posedge clk) begin
    if (req.start) begin
      {d, c, b, a} <= req.chain;
      h            <= req.chain;
    end else if (busy) begin
      a <= d;
      d <= c;
      c <= b;
      b <= b + tt[63:32];
    end
  end

endmodule
`default_nettype wire

### rtl/hme_engine.sv
// Back end of the HMAC-MD5 engine: key and block stores, counters, the job
// sequencer around the MD5 unit, and the result register. Depends on hme_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hme_engine import hme_pkg::*; #(
  parameter int CNT_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output md5_req_t    md5_req,
  input  md5_stat_t   md5_stat,
  output logic [31:0] md5_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] digest_half,
  output logic        last_half
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_KEYW  = 4'd1;
  localparam logic [3:0] ST_KBLK  = 4'd2;
  localparam logic [3:0] ST_KE    = 4'd3;
  localparam logic [3:0] ST_KH1   = 4'd4;
  localparam logic [3:0] ST_KH2   = 4'd5;
  localparam logic [3:0] ST_KDIG  = 4'd6;
  localparam logic [3:0] ST_INNER = 4'd7;
  localparam logic [3:0] ST_MSGW  = 4'd8;
  localparam logic [3:0] ST_MBLK  = 4'd9;
  localparam logic [3:0] ST_F1    = 4'd10;
  localparam logic [3:0] ST_F2    = 4'd11;
  localparam logic [3:0] ST_O1    = 4'd12;
  localparam logic [3:0] ST_O2    = 4'd13;
  localparam logic [3:0] ST_EMIT  = 4'd14;

  localparam logic [1:0] SRC_KEY = 2'd0;
  localparam logic [1:0] SRC_BUF = 2'd1;
  localparam logic [1:0] SRC_DIG = 2'd2;

  function automatic logic [31:0] bswap(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  logic [3:0]          state;
  logic                launched;
  logic                key_ready;
  logic                hashed;
  logic                resume;
  logic [CNT_BITS-1:0] kcount;
  logic [CNT_BITS-1:0] mcount;
  logic [6:0]          key_len;
  logic [1:0]          out_cnt;
  logic [127:0]        chain;
  op_t                 cur_op;
  logic [7:0]          cur_byte;
  logic [31:0]         key_store [16];
  logic [31:0]         blk_buf [16];
  logic [31:0]         inner [4];
  logic [127:0]        res;
  logic [5:0]          kidx;
  logic [5:0]          midx;
  logic                kbig;

  logic                is_job;
  logic                job_done;
  logic [1:0]          jsrc;
  logic [6:0]          jn;
  logic                jmark;
  logic                jlen;
  logic [63:0]         lenbits;
  logic [7:0]          jxor;
  logic                jinit;

  assign kidx     = kcount[5:0];
  assign midx     = mcount[5:0];
  assign kbig     = |kcount[CNT_BITS-1:6];
  assign q_pop    = (state == ST_IDLE) & q_valid;
  assign job_done = is_job & launched & md5_stat.done;

  assign md5_req.start = is_job & ~launched;
  assign md5_req.chain = jinit ? MD5_INIT : chain;

  assign out_valid   = (out_cnt != 2'd0);
  assign last_half   = (out_cnt == 2'd1);
  assign digest_half = (out_cnt == 2'd2) ? res[127:64] : res[63:0];

  // Describe the block job of the current state
  always_comb begin
    is_job  = 1'b1;
    jsrc    = SRC_KEY;
    jn      = 7'd0;
    jmark   = 1'b0;
    jlen    = 1'b0;
    lenbits = 64'(kcount) << 3;
    jxor    = 8'h00;
    jinit   = 1'b0;
    unique case (state)
      ST_KBLK: jn = 7'd64;
      ST_KH1: begin
        jn    = {1'b0, kidx};
        jmark = 1'b1;
        jlen  = (kidx < 6'd56);
      end
      ST_KH2: jlen = 1'b1;
      ST_INNER: begin
        jn    = key_len;
        jxor  = 8'h36;
        jinit = 1'b1;
      end
      ST_MBLK: begin
        jsrc = SRC_BUF;
        jn   = 7'd64;
      end
      ST_F1: begin
        jsrc    = SRC_BUF;
        jn      = {1'b0, midx};
        jmark   = 1'b1;
        jlen    = (midx < 6'd56);
        lenbits = (64'(mcount) + 64'd64) << 3;
      end
      ST_F2: begin
        jsrc    = SRC_BUF;
        jlen    = 1'b1;
        lenbits = (64'(mcount) + 64'd64) << 3;
      end
      ST_O1: begin
        jn    = key_len;
        jxor  = 8'h5c;
        jinit = 1'b1;
      end
      ST_O2: begin
        jsrc    = SRC_DIG;
        jn      = 7'd16;
        jmark   = 1'b1;
        jlen    = 1'b1;
        lenbits = 64'd640;
      end
      default: is_job = 1'b0;
    endcase
  end

  // Build the requested block word: stored bytes, then pad marker and length; every byte XORed with jxor
  always_comb begin
    logic [31:0] srcw;
    logic [5:0]  bi;
    logic [7:0]  bv;
    unique case (jsrc)
      SRC_BUF: srcw = blk_buf[md5_stat.widx];
      SRC_DIG: srcw = inner[md5_stat.widx[1:0]];
      default: srcw = key_store[md5_stat.widx];
    endcase
    md5_word = '0;
    for (int k = 0; k < 4; k++) begin
      bi = {md5_stat.widx, 2'(k)};
      if ({1'b0, bi} < jn) bv = srcw[8*k +: 8];
      else if (({1'b0, bi} == jn) && jmark) bv = 8'h80;
      else if (jlen && (bi[5:3] == 3'b111)) bv = lenbits[8*bi[2:0] +: 8];
      else bv = 8'h00;
      md5_word[8*k +: 8] = bv ^ jxor;
    end
  end

  // Sequence items through key load, inner hash and finish
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      launched  <= 1'b0;
      key_ready <= 1'b0;
      hashed    <= 1'b0;
      resume    <= 1'b0;
      kcount    <= '0;
      mcount    <= '0;
      key_len   <= '0;
      out_cnt   <= '0;
      chain     <= MD5_INIT;
      cur_op    <= OP_KEY;
    end else begin
      if (out_valid && !out_stall) out_cnt <= out_cnt - 1'b1;
      if (is_job) begin
        if (!launched) launched <= 1'b1;
        else if (md5_stat.done) launched <= 1'b0;
      end
      if (job_done) chain <= md5_stat.chain;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur_op <= q_item.op;
            unique case (q_item.op)
              OP_KEY:    state <= ST_KEYW;
              OP_KEYEND: state <= key_ready ? ST_INNER : ST_KE;
              OP_MSG: begin
                if (key_ready) state <= ST_MSGW;
                else begin
                  resume <= 1'b1;
                  state  <= ST_KE;
                end
              end
              default: begin
                if (key_ready) state <= ST_F1;
                else begin
                  resume <= 1'b1;
                  state  <= ST_KE;
                end
              end
            endcase
          end
        end
        ST_KEYW: begin
          if (key_ready) begin
            key_ready <= 1'b0;
            chain     <= MD5_INIT;
          end
          if (kbig) hashed <= 1'b1;
          kcount <= kcount + 1'b1;
          state  <= (kidx == 6'd63) ? ST_KBLK : ST_IDLE;
        end
        ST_KBLK: if (job_done) state <= ST_IDLE;
        ST_KE: begin
          if (hashed) state <= ST_KH1;
          else begin
            key_len <= kbig ? 7'd64 : {1'b0, kidx};
            kcount  <= '0;
            state   <= ST_INNER;
          end
        end
        ST_KH1: if (job_done) state <= (kidx >= 6'd56) ? ST_KH2 : ST_KDIG;
        ST_KH2: if (job_done) state <= ST_KDIG;
        ST_KDIG: begin
          key_len <= 7'd16;
          kcount  <= '0;
          hashed  <= 1'b0;
          state   <= ST_INNER;
        end
        ST_INNER: begin
          if (job_done) begin
            mcount    <= '0;
            key_ready <= 1'b1;
            resume    <= 1'b0;
            if (resume) state <= (cur_op == OP_MSG) ? ST_MSGW : ST_F1;
            else state <= ST_IDLE;
          end
        end
        ST_MSGW: begin
          mcount <= mcount + 1'b1;
          state  <= (midx == 6'd63) ? ST_MBLK : ST_IDLE;
        end
        ST_MBLK: if (job_done) state <= ST_IDLE;
        ST_F1: if (job_done) state <= (midx >= 6'd56) ? ST_F2 : ST_O1;
        ST_F2: if (job_done) state <= ST_O1;
        ST_O1: if (job_done) state <= ST_O2;
        ST_O2: if (job_done) state <= ST_EMIT;
        ST_EMIT: begin
          if (out_cnt == 2'd0) begin
            out_cnt <= 2'd2;
            state   <= ST_INNER;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Hold the payload: stores, inner digest, result
  always_ff @(posedge clk) begin
    if (q_pop) cur_byte <= q_item.data;
    if (state == ST_KEYW) key_store[kidx[5:2]][8*kidx[1:0] +: 8] <= cur_byte;
    if (state == ST_KDIG) begin
      for (int j = 0; j < 4; j++) key_store[j] <= chain[32*j +: 32];
    end
    if (state == ST_MSGW) blk_buf[midx[5:2]][8*midx[1:0] +: 8] <= cur_byte;
    if (job_done && (state == ST_F1 || state == ST_F2)) begin
      for (int j = 0; j < 4; j++) inner[j] <= md5_stat.chain[32*j +: 32];
    end
    if (state == ST_EMIT && out_cnt == 2'd0) begin
      res <= {bswap(chain[31:0]), bswap(chain[63:32]),
              bswap(chain[95:64]), bswap(chain[127:96])};
    end
  end

`ifndef SYNTHESIS
  a_ready_count: assert property (@(posedge clk) disable iff (rst)
    key_ready |-> (kcount == '0))
    else $error("key ready with key bytes pending");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    md5_req.start |-> !md5_stat.busy)
    else $error("md5 start while busy");
  a_done_owned: assert property (@(posedge clk) disable iff (rst)
    md5_stat.done |-> (is_job && launched))
    else $error("md5 done without a waiting job");
  a_emit_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_cnt == 2'd0) |=> (out_cnt == 2'd2))
    else $error("result not loaded");
`endif

endmodule
`default_nettype wire

### rtl/hmac_md5_engine_core.sv
// Top level of the HMAC-MD5 engine: input front queue, job engine and MD5
// round unit. Depends on hme_pkg, hme_front, hme_engine and hme_md5.
`timescale 1ns / 1ps
`default_nettype none
// HMAC-MD5 over a byte stream. Each beat carries a mode (key byte, key end,
// message byte, finish) and a data byte; a finish returns the 16-byte HMAC as
// two 64-bit beats, first byte in the top bits, last_half set on the second.
// A key or message byte is popped from the queue and then stored; each full
// 64-byte block adds a job for the MD5 unit, which runs one round per cycle. A key
// end costs one block (one or two more for a hashed long key), and a finish
// costs four or five blocks. A four-beat queue takes input while the engine
// works, and the result waits in its own register while the engine moves on.
module hmac_md5_engine_core import hme_pkg::*; #(
  parameter int LENGTH_COUNTER_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] digest_half,
  output logic        last_half
);

  logic        q_valid;
  item_t       q_item;
  logic        q_pop;
  md5_req_t    md5_req;
  md5_stat_t   md5_stat;
  logic [31:0] md5_word;

  hme_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .data_byte (data_byte),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  hme_md5 u_md5 (
    .clk  (clk),
    .rst  (rst),
    .req  (md5_req),
    .word (md5_word),
    .stat (md5_stat)
  );

  hme_engine #(
    .CNT_BITS (LENGTH_COUNTER_BITS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .md5_req     (md5_req),
    .md5_stat    (md5_stat),
    .md5_word    (md5_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_half (digest_half),
    .last_half   (last_half)
  );

endmodule
`default_nettype wire
